/* rtl/core/lttu_pkg.sv */
// Shared types and constants for the LRU TLB page translator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lttu_pkg;
  localparam int unsigned CountW = 16;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_TLB   = 6'b000010,
    ST_TBL   = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  // Per-cycle command broadcast to every cell of a chain.
  typedef struct packed {
    logic promote;
    logic append;
    logic full;
  } cell_ctl_t;
endpackage
`default_nettype wire

/* rtl/core/lttu_cell.sv */
// One LRU slot: holds a page/frame pair, matches against the lookup page
// and shifts toward slot 0 on promote or full append. Uses lttu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lttu_cell #(
  parameter int unsigned PageW  = 8,
  parameter int unsigned FrameW = 8
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire lttu_pkg::cell_ctl_t ctl,
  input  wire [PageW-1:0]   key_page,
  input  wire [PageW-1:0]   new_page,
  input  wire [FrameW-1:0]  new_frame,
  input  wire               is_tail,      // this slot is fill-1 (promote) or append slot
  input  wire               shift_in_en,  // this slot is at or above the hit index
  input  wire               nb_valid,
  input  wire [PageW-1:0]   nb_page,
  input  wire [FrameW-1:0]  nb_frame,
  output logic              valid,
  output logic [PageW-1:0]  page,
  output logic [FrameW-1:0] frame,
  output logic              match
);
  logic              valid_r;
  logic [PageW-1:0]  page_r;
  logic [FrameW-1:0] frame_r;

  assign valid = valid_r;
  assign page  = page_r;
  assign frame = frame_r;
  assign match = valid_r && (page_r == key_page);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (is_tail && (ctl.promote || ctl.append)) begin
      valid_r <= 1'b1;
      page_r  <= new_page;
      frame_r <= new_frame;
    end else if ((ctl.promote && shift_in_en) || (ctl.append && ctl.full)) begin
      valid_r <= nb_valid;
      page_r  <= nb_page;
      frame_r <= nb_frame;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/lttu_chain.sv */
// LRU-ordered row of lttu_cell slots (oldest at slot 0) with its fill count
// and hit encoder. Uses lttu_pkg and lttu_cell.
`timescale 1ns / 1ps
`default_nettype none
module lttu_chain #(
  parameter int unsigned Depth  = 16,
  parameter int unsigned PageW  = 8,
  parameter int unsigned FrameW = 8
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                do_promote,
  input  wire                do_append,
  input  wire [PageW-1:0]    key_page,
  input  wire [FrameW-1:0]   new_frame,
  output logic               hit,
  output logic [FrameW-1:0]  hit_frame,
  output logic [Depth-1:0]   valid_vec,
  output logic [Depth*FrameW-1:0] frame_vec
);
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FillW = $clog2(Depth + 1);

  logic [FillW-1:0]  fill_r, fill_nxt;
  logic [Depth-1:0]  v, m, at_or_above;
  logic [PageW-1:0]  pg [Depth];
  logic [FrameW-1:0] fr [Depth];
  logic [IdxW-1:0]   hit_idx;
  logic              full;
  lttu_pkg::cell_ctl_t ctl;

  assign full = (fill_r == FillW'(Depth));
  assign ctl  = {do_promote, do_append, full};

  always_comb begin
    hit_idx = '0;
    for (int i = Depth - 1; i >= 0; i--) if (m[i]) hit_idx = IdxW'(i);
    hit_frame = '0;
    for (int i = 0; i < Depth; i++) if (m[i]) hit_frame = fr[i];
  end
  assign hit = |m;

  always_comb begin
    for (int i = 0; i < Depth; i++) at_or_above[i] = (IdxW'(i) >= hit_idx);
  end

  genvar g;
  generate
    for (g = 0; g < Depth; g++) begin : g_cell
      logic tail;
      logic nv;
      logic [PageW-1:0]  np;
      logic [FrameW-1:0] nf;
      if (g == Depth - 1) begin : g_top
        assign nv = 1'b0;
        assign np = '0;
        assign nf = '0;
      end else begin : g_mid
        assign nv = v[g+1];
        assign np = pg[g+1];
        assign nf = fr[g+1];
      end
      assign tail = do_promote ? (FillW'(g) == fill_r - FillW'(1))
                  : full ? (g == Depth - 1) : (FillW'(g) == fill_r);
      lttu_cell #(.PageW(PageW), .FrameW(FrameW)) u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .key_page(key_page),
        .new_page(key_page),
        .new_frame(do_promote ? hit_frame : new_frame),
        .is_tail(tail), .shift_in_en(at_or_above[g]),
        .nb_valid(nv), .nb_page(np), .nb_frame(nf),
        .valid(v[g]), .page(pg[g]), .frame(fr[g]), .match(m[g])
      );
      assign frame_vec[g*FrameW +: FrameW] = fr[g];
    end
  endgenerate
  assign valid_vec = v;

  always_comb begin
    fill_nxt = fill_r;
    if (do_append && !full) fill_nxt = fill_r + FillW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fill_r <= '0;
    else fill_r <= fill_nxt;
  end
endmodule
`default_nettype wire

/* rtl/core/lru_tlb_page_translator_unit.sv */
// Top level of the LRU TLB page translator: sequencer, counters, frame scan.
// Uses lttu_pkg, lttu_chain, lttu_cell.
//
// Raise start for one cycle while busy is low to translate in_logical_address.
// A TLB hit passes ST_TLB and then ST_DONE, a page-table hit ST_TLB, ST_TBL and
// ST_DONE, a fault with fresh frames also ST_WRITE; once all FRAME_COUNT
// frames were handed out, a fault scans one frame per cycle for the lowest
// unused one (frame 0 if none is free). busy stays high until the result
// strobe out_valid, which lasts exactly one cycle and cannot be held off;
// start may be raised again in the cycle after it.
`timescale 1ns / 1ps
`default_nettype none
module lru_tlb_page_translator_unit #(
  parameter int unsigned TLB_DEPTH   = 16,
  parameter int unsigned TABLE_DEPTH = 128,
  parameter int unsigned FRAME_COUNT = 256,
  parameter int unsigned OFFSET_BITS = 8
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  [15:0] in_logical_address,
  output logic        out_valid,
  output logic [15:0] out_physical_address,
  output logic        out_tlb_hit,
  output logic        out_page_fault,
  output logic [15:0] out_fault_total,
  output logic [15:0] out_hit_total
);
  localparam int unsigned PageW  = 16 - OFFSET_BITS;
  localparam int unsigned FrameW = $clog2(FRAME_COUNT);
  localparam int unsigned FreshW = FrameW + 1;

  lttu_pkg::state_t state_r, state_nxt;
  logic [15:0]       addr_r;
  logic [FrameW-1:0] frame_r, frame_nxt;
  logic              hit_r, fault_r;
  logic [FreshW-1:0] fresh_r;
  logic [FreshW-1:0] scan_r;
  logic [15:0]       faults_r, hits_r;
  logic [PageW-1:0]  key;

  logic t_hit, b_hit;
  logic [FrameW-1:0] t_frame, b_frame;
  logic [TLB_DEPTH-1:0]   t_valid;
  logic [TABLE_DEPTH-1:0] b_valid;
  logic [TLB_DEPTH*FrameW-1:0]   t_fv;
  logic [TABLE_DEPTH*FrameW-1:0] b_fv;
  logic t_prom, b_prom, app;
  logic used;

  assign key = addr_r[15:OFFSET_BITS];

  lttu_chain #(.Depth(TLB_DEPTH), .PageW(PageW), .FrameW(FrameW)) u_tlb (
    .clk(clk), .rst_n(rst_n), .do_promote(t_prom), .do_append(app),
    .key_page(key), .new_frame(frame_r), .hit(t_hit), .hit_frame(t_frame),
    .valid_vec(t_valid), .frame_vec(t_fv)
  );
  lttu_chain #(.Depth(TABLE_DEPTH), .PageW(PageW), .FrameW(FrameW)) u_tbl (
    .clk(clk), .rst_n(rst_n), .do_promote(b_prom), .do_append(app),
    .key_page(key), .new_frame(frame_r), .hit(b_hit), .hit_frame(b_frame),
    .valid_vec(b_valid), .frame_vec(b_fv)
  );

  // one candidate frame per cycle against every slot
  always_comb begin
    used = 1'b0;
    for (int i = 0; i < TLB_DEPTH; i++)
      if (t_valid[i] && t_fv[i*FrameW +: FrameW] == scan_r[FrameW-1:0]) used = 1'b1;
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (b_valid[i] && b_fv[i*FrameW +: FrameW] == scan_r[FrameW-1:0]) used = 1'b1;
  end

  assign t_prom = (state_r == lttu_pkg::ST_TLB) && t_hit;
  assign b_prom = (state_r == lttu_pkg::ST_TBL) && b_hit;
  assign app    = (state_r == lttu_pkg::ST_WRITE);
  assign busy   = (state_r != lttu_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    frame_nxt = frame_r;
    unique case (state_r)
      lttu_pkg::ST_IDLE:  if (start) state_nxt = lttu_pkg::ST_TLB;
      lttu_pkg::ST_TLB: begin
        frame_nxt = t_frame;
        state_nxt = t_hit ? lttu_pkg::ST_DONE : lttu_pkg::ST_TBL;
      end
      lttu_pkg::ST_TBL: begin
        if (b_hit) begin
          frame_nxt = b_frame;
          state_nxt = lttu_pkg::ST_DONE;
        end else if (fresh_r < FreshW'(FRAME_COUNT)) begin
          frame_nxt = fresh_r[FrameW-1:0];
          state_nxt = lttu_pkg::ST_WRITE;
        end else begin
          state_nxt = lttu_pkg::ST_SCAN;
        end
      end
      lttu_pkg::ST_SCAN: begin
        if (!used) begin
          frame_nxt = scan_r[FrameW-1:0];
          state_nxt = lttu_pkg::ST_WRITE;
        end else if (scan_r == FreshW'(FRAME_COUNT - 1)) begin
          frame_nxt = '0;
          state_nxt = lttu_pkg::ST_WRITE;
        end
      end
      lttu_pkg::ST_WRITE: state_nxt = lttu_pkg::ST_DONE;
      lttu_pkg::ST_DONE:  state_nxt = lttu_pkg::ST_IDLE;
      default:            state_nxt = lttu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lttu_pkg::ST_IDLE;
      fresh_r  <= '0;
      faults_r <= '0;
      hits_r   <= '0;
      hit_r    <= 1'b0;
      fault_r  <= 1'b0;
      scan_r   <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        lttu_pkg::ST_IDLE: begin
          hit_r   <= 1'b0;
          fault_r <= 1'b0;
          scan_r  <= '0;
        end
        lttu_pkg::ST_TLB: if (t_hit) begin
          hit_r <= 1'b1;
          if (hits_r != lttu_pkg::CountMax) hits_r <= hits_r + 16'd1;
        end
        lttu_pkg::ST_TBL: if (!b_hit) begin
          fault_r <= 1'b1;
          if (faults_r != lttu_pkg::CountMax) faults_r <= faults_r + 16'd1;
          if (fresh_r < FreshW'(FRAME_COUNT)) fresh_r <= fresh_r + FreshW'(1);
        end
        lttu_pkg::ST_SCAN: scan_r <= scan_r + FreshW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) addr_r <= in_logical_address;
    frame_r <= frame_nxt;
  end

  logic [15:0] frame_ext;
  assign frame_ext = 16'(frame_r);

  assign out_valid            = (state_r == lttu_pkg::ST_DONE);
  assign out_physical_address = 16'(frame_ext << OFFSET_BITS)
                              | (addr_r & 16'((17'd1 << OFFSET_BITS) - 17'd1));
  assign out_tlb_hit          = hit_r;
  assign out_page_fault       = fault_r;
  assign out_fault_total      = faults_r;
  assign out_hit_total        = hits_r;
endmodule
`default_nettype wire

/* verif/tb.sv */
// Self-checking bench for lru_tlb_page_translator_unit: directed and random address beats,
// checked against a behavioral LRU TLB / page table / frame allocator model.
// Depends on the RTL top level only.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  localparam int TlbDepth   = 16;
  localparam int TableDepth = 128;
  localparam int FrameCount = 256;
  localparam int CycleLimit = 2000000;

  typedef struct {
    logic [15:0] phys;
    logic        hit;
    logic        fault;
    logic [15:0] faults;
    logic [15:0] hits;
  } xlate_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [15:0] in_logical_address = '0;
  wire         busy;
  wire         out_valid;
  wire  [15:0] out_physical_address;
  wire         out_tlb_hit;
  wire         out_page_fault;
  wire  [15:0] out_fault_total;
  wire  [15:0] out_hit_total;

  lru_tlb_page_translator_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_logical_address(in_logical_address),
    .out_valid(out_valid), .out_physical_address(out_physical_address),
    .out_tlb_hit(out_tlb_hit), .out_page_fault(out_page_fault),
    .out_fault_total(out_fault_total), .out_hit_total(out_hit_total)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [7:0]  tlb_page [TlbDepth];
  logic [7:0]  tlb_frame [TlbDepth];
  int          tlb_count;
  logic [7:0]  tbl_page [TableDepth];
  logic [7:0]  tbl_frame [TableDepth];
  int          tbl_count;
  int          fresh_frame;
  logic [15:0] fault_cnt;
  logic [15:0] hit_cnt;
  xlate_t      pending_xlates[$];
  int          mismatches;
  int          cycles;
  bit          burst_idle;

  function automatic xlate_t translate(input logic [15:0] addr);
    xlate_t r;
    logic [7:0] pg;
    logic [7:0] fr;
    int idx;
    bit used [FrameCount];
    pg = addr[15:8];
    fr = '0;
    r.hit = 1'b0;
    r.fault = 1'b0;
    idx = -1;
    for (int i = 0; i < tlb_count; i++) if (idx < 0 && tlb_page[i] == pg) idx = i;
    if (idx >= 0) begin
      fr = tlb_frame[idx];
      r.hit = 1'b1;
      if (hit_cnt != 16'hFFFF) hit_cnt++;
      for (int k = idx; k + 1 < tlb_count; k++) begin
        tlb_page[k] = tlb_page[k+1];
        tlb_frame[k] = tlb_frame[k+1];
      end
      tlb_page[tlb_count-1] = pg;
      tlb_frame[tlb_count-1] = fr;
    end else begin
      for (int i = 0; i < tbl_count; i++) if (idx < 0 && tbl_page[i] == pg) idx = i;
      if (idx >= 0) begin
        fr = tbl_frame[idx];
        for (int k = idx; k + 1 < tbl_count; k++) begin
          tbl_page[k] = tbl_page[k+1];
          tbl_frame[k] = tbl_frame[k+1];
        end
        tbl_page[tbl_count-1] = pg;
        tbl_frame[tbl_count-1] = fr;
      end else begin
        r.fault = 1'b1;
        if (fresh_frame < FrameCount) begin
          fr = fresh_frame[7:0];
          fresh_frame++;
        end else begin
          foreach (used[i]) used[i] = 1'b0;
          for (int i = 0; i < tlb_count; i++) used[tlb_frame[i]] = 1'b1;
          for (int i = 0; i < tbl_count; i++) used[tbl_frame[i]] = 1'b1;
          idx = -1;
          for (int i = 0; i < FrameCount; i++) if (idx < 0 && !used[i]) idx = i;
          fr = (idx < 0) ? 8'd0 : idx[7:0];
        end
        if (fault_cnt != 16'hFFFF) fault_cnt++;
        if (tlb_count == TlbDepth) begin
          for (int k = 0; k + 1 < TlbDepth; k++) begin
            tlb_page[k] = tlb_page[k+1];
            tlb_frame[k] = tlb_frame[k+1];
          end
          tlb_count--;
        end
        tlb_page[tlb_count] = pg;
        tlb_frame[tlb_count] = fr;
        tlb_count++;
        if (tbl_count == TableDepth) begin
          for (int k = 0; k + 1 < TableDepth; k++) begin
            tbl_page[k] = tbl_page[k+1];
            tbl_frame[k] = tbl_frame[k+1];
          end
          tbl_count--;
        end
        tbl_page[tbl_count] = pg;
        tbl_frame[tbl_count] = fr;
        tbl_count++;
      end
    end
    r.phys = {fr, addr[7:0]};
    r.faults = fault_cnt;
    r.hits = hit_cnt;
    return r;
  endfunction

  task automatic send_beat(input logic [15:0] addr);
    if (burst_idle) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_logical_address <= addr;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_xlates.push_back(translate(addr));
    start <= 1'b0;
    in_logical_address <= 16'($urandom);
    @(posedge clk);
    while (busy) @(posedge clk);
    if ($urandom_range(0, 15) == 0) burst_idle = !burst_idle;
  endtask

  always @(posedge clk) begin
    if (out_valid) begin
      xlate_t e;
      if (pending_xlates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat phys=%h", out_physical_address);
      end else begin
        e = pending_xlates.pop_front();
        if (e.phys !== out_physical_address || e.hit !== out_tlb_hit ||
            e.fault !== out_page_fault || e.faults !== out_fault_total ||
            e.hits !== out_hit_total) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %h/%b/%b/%h/%h got %h/%b/%b/%h/%h",
                     e.phys, e.hit, e.fault, e.faults, e.hits,
                     out_physical_address, out_tlb_hit, out_page_fault,
                     out_fault_total, out_hit_total);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_beat(16'h0000);
    send_beat(16'h00FF);
    send_beat(16'hFFFF);
    send_beat(16'hFF00);
    send_beat(16'hAA55);
    send_beat(16'h5500);
    for (int i = 0; i < 17; i++) send_beat({8'(i + 16), 8'h3C});
    send_beat(16'h0012);
  endtask

  // working set of span pages plus random pages, exercises hit, table hit and eviction
  task automatic test_locality(input int n, input int span);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_beat(16'($urandom));
      else send_beat({8'($urandom_range(0, span - 1)), 8'($urandom)});
    end
  endtask

  initial begin
    burst_idle = 1'b0;
    tlb_count = 0;
    tbl_count = 0;
    fresh_frame = 0;
    fault_cnt = '0;
    hit_cnt = '0;
    mismatches = 0;
    cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_locality(500, 20);
    test_locality(500, 140);
    test_locality(600, 256);
    test_locality(400, 40);
    repeat (50) @(posedge clk);
    while (pending_xlates.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
